/* rtl/bla_pkg.sv */
package bla_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CNT_W    = 16;

  // Number of warning beeps after the LED hold (1 to 3).
  localparam logic [1:0] BEEP_COUNT = 2'd2;

  // Longest chain of zero-length phases that can end within one item:
  // hold, then an on/off pair per beep, plus the closing step.
  localparam int unsigned FINISH_STEPS = 2 * int'(BEEP_COUNT) + 2;

  typedef logic [2:0] level_t;
  localparam level_t LV_OFF        = 3'd0;
  localparam level_t LV_SETTLING   = 3'd1;
  localparam level_t LV_MONITORING = 3'd2;
  localparam level_t LV_WARNED     = 3'd3;
  localparam level_t LV_ALARM      = 3'd4;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_SETTLE   = 7'b0000010,
    PH_FLASH    = 7'b0000100,
    PH_BLANK    = 7'b0001000,
    PH_HOLD     = 7'b0010000,
    PH_BEEP_ON  = 7'b0100000,
    PH_BEEP_OFF = 7'b1000000
  } phase_t;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_WARN_LEVEL    = 3'd0;
  localparam reg_idx_t REG_ALARM_LEVEL   = 3'd1;
  localparam reg_idx_t REG_PRESENT_LEVEL = 3'd2;
  localparam reg_idx_t REG_SETTLE_MS     = 3'd3;
  localparam reg_idx_t REG_BLANK_MS      = 3'd4;
  localparam reg_idx_t REG_WARN_HOLD_MS  = 3'd5;
  localparam reg_idx_t REG_BEEP_ON_MS    = 3'd6;
  localparam reg_idx_t REG_BEEP_OFF_MS   = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] warn_level;
    logic [SAMPLE_W-1:0] alarm_level;
    logic [SAMPLE_W-1:0] present_level;
    logic [CNT_W-1:0]    settle_ms;
    logic [CNT_W-1:0]    blank_ms;
    logic [CNT_W-1:0]    warn_hold_ms;
    logic [CNT_W-1:0]    beep_on_ms;
    logic [CNT_W-1:0]    beep_off_ms;
  } cfg_regs_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] wait_cnt;
    level_t           level;
    logic [1:0]       beeps;
    logic             led;
    logic             buzzer;
  } chan_state_t;

  typedef struct packed {
    level_t level;
    logic   buzzer;
    logic   led;
  } result_t;

endpackage

/* rtl/bla_cfg_regs.sv */
module bla_cfg_regs import bla_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  reg_idx_t            cfg_index,
  input  logic [CNT_W-1:0]    cfg_data,
  output logic                cfg_ready,
  output cfg_regs_t           cfg_o
);

  cfg_regs_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warn_level    <= 16'd26326;
      cfg_r.alarm_level   <= 16'd24960;
      cfg_r.present_level <= 16'd14037;
      cfg_r.settle_ms     <= 16'd500;
      cfg_r.blank_ms      <= 16'd2000;
      cfg_r.warn_hold_ms  <= 16'd5000;
      cfg_r.beep_on_ms    <= 16'd800;
      cfg_r.beep_off_ms   <= 16'd500;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WARN_LEVEL:    cfg_r.warn_level    <= cfg_data;
        REG_ALARM_LEVEL:   cfg_r.alarm_level   <= cfg_data;
        REG_PRESENT_LEVEL: cfg_r.present_level <= cfg_data;
        REG_SETTLE_MS:     cfg_r.settle_ms     <= cfg_data;
        REG_BLANK_MS:      cfg_r.blank_ms      <= cfg_data;
        REG_WARN_HOLD_MS:  cfg_r.warn_hold_ms  <= cfg_data;
        REG_BEEP_ON_MS:    cfg_r.beep_on_ms    <= cfg_data;
        REG_BEEP_OFF_MS:   cfg_r.beep_off_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/bla_core.sv */
module bla_core import bla_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                blink_tick,
  input  cfg_regs_t           cfg,
  output result_t             res_nxt
);

  chan_state_t st_r;
  chan_state_t st_nxt;
  chan_state_t s;

  // Judge one sample while no countdown runs.
  function automatic chan_state_t judge(chan_state_t s_in, logic [SAMPLE_W-1:0] smp,
                                        cfg_regs_t c);
    chan_state_t j;
    logic        done;
    j    = s_in;
    done = 1'b0;
    if (smp < c.present_level && j.level == LV_ALARM) begin
      j.level  = LV_OFF;
      j.led    = 1'b0;
      j.buzzer = 1'b0;
    end
    if (j.level == LV_SETTLING) begin
      j.phase    = PH_SETTLE;
      j.wait_cnt = c.settle_ms;
      done       = 1'b1;
    end else if (j.level == LV_MONITORING) begin
      if (smp <= c.warn_level) begin
        j.phase    = PH_HOLD;
        j.led      = 1'b1;
        j.wait_cnt = c.warn_hold_ms;
        done       = 1'b1;
      end else begin
        j.level = LV_SETTLING;
      end
    end
    if (!done) begin
      if (smp <= c.alarm_level && (j.level == LV_SETTLING || j.level == LV_WARNED)) begin
        j.level = LV_ALARM;
      end
      if (smp >= c.present_level && j.level == LV_OFF) begin
        j.level    = LV_SETTLING;
        j.phase    = PH_FLASH;
        j.led      = 1'b1;
        j.buzzer   = 1'b1;
        j.wait_cnt = c.settle_ms;
      end
    end
    return j;
  endfunction

  // End the running phase if its countdown has expired and start the next one.
  function automatic chan_state_t finish_step(chan_state_t s_in, cfg_regs_t c);
    chan_state_t f;
    logic [1:0]  nb;
    f  = s_in;
    nb = s_in.beeps + 2'd1;
    if (s_in.phase != PH_IDLE && s_in.wait_cnt == '0) begin
      case (s_in.phase)
        PH_SETTLE: begin
          f.level    = LV_MONITORING;
          f.phase    = PH_IDLE;
          f.wait_cnt = '0;
        end
        PH_FLASH: begin
          f.led      = 1'b0;
          f.buzzer   = 1'b0;
          f.phase    = PH_BLANK;
          f.wait_cnt = c.blank_ms;
        end
        PH_HOLD: begin
          f.level    = LV_WARNED;
          f.beeps    = 2'd0;
          f.phase    = PH_BEEP_ON;
          f.buzzer   = 1'b1;
          f.wait_cnt = c.beep_on_ms;
        end
        PH_BEEP_ON: begin
          f.phase    = PH_BEEP_OFF;
          f.buzzer   = 1'b0;
          f.wait_cnt = c.beep_off_ms;
        end
        PH_BEEP_OFF: begin
          f.beeps = nb;
          if (nb < BEEP_COUNT && nb != 2'd0) begin
            f.phase    = PH_BEEP_ON;
            f.buzzer   = 1'b1;
            f.wait_cnt = c.beep_on_ms;
          end else begin
            f.phase    = PH_IDLE;
            f.wait_cnt = '0;
          end
        end
        default: begin
          f.phase    = PH_IDLE;
          f.wait_cnt = '0;
        end
      endcase
    end
    return f;
  endfunction

  always_comb begin
    s = st_r;
    if (s.phase != PH_IDLE) begin
      if (s.wait_cnt != '0) begin
        s.wait_cnt = s.wait_cnt - 16'd1;
      end
    end else begin
      s = judge(s, sample, cfg);
    end
    for (int i = 0; i < FINISH_STEPS; i++) begin
      s = finish_step(s, cfg);
    end
    if (s.level == LV_ALARM && blink_tick) begin
      s.led    = ~s.led;
      s.buzzer = ~s.buzzer;
    end
    st_nxt = s;
  end

  assign res_nxt.led    = st_nxt.led;
  assign res_nxt.buzzer = st_nxt.buzzer;
  assign res_nxt.level  = st_nxt.level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase    <= PH_IDLE;
      st_r.wait_cnt <= '0;
      st_r.level    <= LV_OFF;
      st_r.beeps    <= 2'd0;
      st_r.led      <= 1'b0;
      st_r.buzzer   <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_IDLE) |-> (st_r.wait_cnt == '0))
    else $error("countdown left running in idle phase");

  a_presence_seq_level: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_SETTLE || st_r.phase == PH_FLASH || st_r.phase == PH_BLANK)
      |-> (st_r.level == LV_SETTLING))
    else $error("presence sequence running outside settling level");

  a_warn_seq_level: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_BEEP_ON || st_r.phase == PH_BEEP_OFF)
      |-> (st_r.level == LV_WARNED && st_r.buzzer == (st_r.phase == PH_BEEP_ON)))
    else $error("beep phase disagrees with level or buzzer");

  a_hold_level: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_HOLD) |-> (st_r.level == LV_MONITORING && st_r.led))
    else $error("warning hold without lit LED in monitoring level");

  a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("channel state moved without an item");

endmodule

/* rtl/battery_level_alarm_unit.sv */
// Battery level alarm for one channel. Every input item is one 1 ms tick with the latest
// raw converter sample and a blink flag; every item yields exactly one result item with the
// LED drive, the buzzer drive and the channel level (0 off, 1 settling, 2 monitoring,
// 3 warned, 4 alarm). The unit takes one item per clock cycle while the result side does
// not stall; each item waits in the input register, then one pass of the state update
// writes its result into the result register, and both registers keep moving while the
// other side stalls only as far as the result register is free. Thresholds compare in raw
// counts, all waits count ticks, and configuration writes (one register per write, index
// 0 to 7) are taken in any cycle but must only be issued while no item is in flight. No
// memory, no clearing pass.
module battery_level_alarm_unit import bla_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [15:0] sample, [16] blink_tick, [23:17] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // out_tdata: [0] led, [1] buzzer, [4:2] level_state, [7:5] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_regs_t           cfg;
  result_t             res_nxt;

  // Input stage: holds one accepted item until the update pass consumes it.
  logic                in_valid_r;
  logic [SAMPLE_W-1:0] in_sample_r;
  logic                in_blink_r;

  // Result stage.
  logic                out_valid_r;
  result_t             out_res_r;

  logic                advance;
  logic                in_take;

  // Move the held item through the update pass whenever the result register is free
  // or is being emptied in this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  bla_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg_o     (cfg)
  );

  bla_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .sample     (in_sample_r),
    .blink_tick (in_blink_r),
    .cfg        (cfg),
    .res_nxt    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Capture payload only on a new item; hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_sample_r <= in_tdata[15:0];
      in_blink_r  <= in_tdata[16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.level, out_res_r.buzzer, out_res_r.led};

endmodule
